>>> rtl/cbm_pkg.sv
package cbm_pkg;

    // Field widths of one bus access and one result.
    localparam int ADDR_W     = 16;
    localparam int DATA_W     = 8;
    localparam int KIND_W     = 2;
    localparam int ROM_ADDR_W = 23;

    // Bank geometry.  The RAM holds four banks of 8 KiB; a ROM bank is 16 KiB.
    localparam int ROM_BANK_W     = 9;
    localparam int ROM_OFFSET_W   = 14;
    localparam int RAM_BANK_W     = 2;
    localparam int RAM_OFFSET_W   = 13;
    localparam int RAM_AW         = RAM_BANK_W + RAM_OFFSET_W;
    localparam int RAM_DEPTH      = 1 << RAM_AW;

    typedef logic [KIND_W-1:0]     t_kind;
    typedef logic [ADDR_W-1:0]     t_addr;
    typedef logic [DATA_W-1:0]     t_data;
    typedef logic [ROM_ADDR_W-1:0] t_rom_addr;

    localparam t_kind KIND_ROM_ADDR   = 2'd0;
    localparam t_kind KIND_DATA       = 2'd1;
    localparam t_kind KIND_WRITE_DONE = 2'd2;

    localparam logic CMD_READ  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    // Address regions, taken from the top three address bits.
    typedef logic [2:0] t_region;
    localparam t_region REG_0000 = 3'd0;
    localparam t_region REG_2000 = 3'd1;
    localparam t_region REG_4000 = 3'd2;
    localparam t_region REG_6000 = 3'd3;
    localparam t_region REG_A000 = 3'd5;

    localparam t_data RAM_ENABLE_KEY  = 8'h0A;
    localparam t_data RAM_DISABLE_KEY = 8'h00;
    localparam t_data RAM_BANK_MAX    = 8'h03;
    localparam t_data UNMAPPED_BYTE   = 8'hFF;

endpackage

>>> rtl/cbm_if.sv
interface cbm_req_if;
    logic            valid;
    logic            ready;
    logic            command;
    cbm_pkg::t_addr  bus_address;
    cbm_pkg::t_data  write_data;

    modport source (output valid, output command, output bus_address, output write_data,
                    input ready);
    modport sink   (input valid, input command, input bus_address, input write_data,
                    output ready);
endinterface

interface cbm_rsp_if;
    logic               valid;
    logic               ready;
    cbm_pkg::t_kind     result_kind;
    cbm_pkg::t_rom_addr rom_address;
    cbm_pkg::t_data     read_data;

    modport source (output valid, output result_kind, output rom_address, output read_data,
                    input ready);
    modport sink   (input valid, input result_kind, input rom_address, input read_data,
                    output ready);
endinterface

>>> rtl/cartridge_bank_mapper.sv
// Channel   Direction  Payload
// i_req     in         command, bus_address, write_data
// o_rsp     out        result_kind, rom_address, read_data
//
// One item is accepted per cycle except during RAM clearing or an output stall
// with both registers full.  A result passes the registered RAM read port and
// first register, then the output register.  Bank registers and RAM writes take
// effect at acceptance.  After reset the RAM is cleared one byte a cycle, with
// i_req.ready low meanwhile.  A stalled output holds a result and one in flight.
module cartridge_bank_mapper (
    input  logic i_clk,
    input  logic i_rst_n,
    cbm_req_if.sink   i_req,
    cbm_rsp_if.source o_rsp
);
    import cbm_pkg::*;

    t_data mem [RAM_DEPTH];
    t_data r_mem_q;

    logic                  r_clr_busy;
    logic [RAM_AW-1:0]     r_clr_idx;

    logic [ROM_BANK_W-1:0] r_rom_bank;
    logic [RAM_BANK_W-1:0] r_ram_bank;
    logic                  r_ram_en;

    logic      r_s1_valid, r_s1_use_mem;
    t_kind     r_s1_kind;
    t_rom_addr r_s1_rom;
    t_data     r_s1_rdata;

    logic      r_s2_valid;
    t_kind     r_s2_kind;
    t_rom_addr r_s2_rom;
    t_data     r_s2_rdata;

    logic              acc, s1_adv, is_wr;
    t_region           region;
    logic [RAM_AW-1:0] ram_idx;
    logic              mem_we, mem_re;
    logic [RAM_AW-1:0] mem_wa;
    t_data             mem_wd;
    t_kind             n_kind;
    t_rom_addr         n_rom;
    t_data             n_rdata;
    logic              n_use_mem;

    assign s1_adv      = !r_s2_valid || o_rsp.ready;
    assign i_req.ready = !r_clr_busy && (!r_s1_valid || s1_adv);
    assign acc         = i_req.valid && i_req.ready;
    assign is_wr       = (i_req.command == CMD_WRITE);
    assign region      = i_req.bus_address[ADDR_W-1 -: 3];
    assign ram_idx     = {r_ram_bank, i_req.bus_address[RAM_OFFSET_W-1:0]};

    // RAM port: the clearing pass owns it until it has swept every byte.
    always_comb begin
        mem_we = 1'b0;
        mem_wa = ram_idx;
        mem_wd = i_req.write_data;
        mem_re = acc && !is_wr && (region == REG_A000);
        if (r_clr_busy) begin
            mem_we = 1'b1;
            mem_wa = r_clr_idx;
            mem_wd = '0;
        end else if (acc && is_wr && (region == REG_A000) && r_ram_en) begin
            mem_we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            r_mem_q <= mem[ram_idx];
        end
    end

    // Result fields of the accepted item, apart from the RAM byte.
    always_comb begin
        n_kind    = KIND_DATA;
        n_rom     = '0;
        n_rdata   = '0;
        n_use_mem = 1'b0;
        if (is_wr) begin
            n_kind = KIND_WRITE_DONE;
        end else begin
            case (region)
                REG_0000, REG_2000: begin
                    n_kind = KIND_ROM_ADDR;
                    n_rom  = {{ROM_BANK_W{1'b0}}, i_req.bus_address[ROM_OFFSET_W-1:0]};
                end
                REG_4000, REG_6000: begin
                    n_kind = KIND_ROM_ADDR;
                    n_rom  = {r_rom_bank, i_req.bus_address[ROM_OFFSET_W-1:0]};
                end
                REG_A000: begin
                    n_use_mem = 1'b1;
                end
                default: begin
                    n_rdata = UNMAPPED_BYTE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_idx  <= '0;
            r_rom_bank <= '0;
            r_ram_bank <= '0;
            r_ram_en   <= 1'b0;
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            if (r_clr_busy) begin
                r_clr_idx <= r_clr_idx + 1'b1;
                if (&r_clr_idx) begin
                    r_clr_busy <= 1'b0;
                end
            end

            if (acc && is_wr) begin
                case (region)
                    REG_0000: begin
                        if (i_req.write_data == RAM_ENABLE_KEY) begin
                            r_ram_en <= 1'b1;
                        end else if (i_req.write_data == RAM_DISABLE_KEY) begin
                            r_ram_en <= 1'b0;
                        end
                    end
                    REG_2000: begin
                        // Bit 12 splits the low byte from the ninth bank bit.
                        if (!i_req.bus_address[12]) begin
                            r_rom_bank[7:0] <= i_req.write_data;
                        end else begin
                            r_rom_bank[8] <= i_req.write_data[0];
                        end
                    end
                    REG_4000: begin
                        if (i_req.write_data <= RAM_BANK_MAX) begin
                            r_ram_bank <= i_req.write_data[RAM_BANK_W-1:0];
                        end
                    end
                    default: ;
                endcase
            end

            if (acc) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end

            if (r_s1_valid && s1_adv) begin
                r_s2_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_s2_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_s1_kind    <= n_kind;
            r_s1_rom     <= n_rom;
            r_s1_rdata   <= n_rdata;
            r_s1_use_mem <= n_use_mem;
        end
        if (r_s1_valid && s1_adv) begin
            r_s2_kind  <= r_s1_kind;
            r_s2_rom   <= r_s1_rom;
            r_s2_rdata <= r_s1_use_mem ? r_mem_q : r_s1_rdata;
        end
    end

    assign o_rsp.valid       = r_s2_valid;
    assign o_rsp.result_kind = r_s2_kind;
    assign o_rsp.rom_address = r_s2_rom;
    assign o_rsp.read_data   = r_s2_rdata;

    a_no_accept_while_clearing: assert property (@(posedge i_clk)
        r_clr_busy |-> !i_req.ready)
        else $error("item accepted during RAM clearing pass");

    a_nothing_in_flight_while_clearing: assert property (@(posedge i_clk)
        disable iff (!i_rst_n) r_clr_busy |-> (!r_s1_valid && !r_s2_valid))
        else $error("pipeline holds an item during RAM clearing pass");

    a_write_gives_done: assert property (@(posedge i_clk)
        disable iff (!i_rst_n) (acc && is_wr) |=> (r_s1_kind == KIND_WRITE_DONE))
        else $error("accepted write did not produce a write-done result");

    a_enable_only_by_write: assert property (@(posedge i_clk)
        disable iff (!i_rst_n) !$stable(r_ram_en) |-> $past(acc && is_wr))
        else $error("RAM enable changed without a write");

    a_stalled_s1_keeps_ram_byte: assert property (@(posedge i_clk)
        disable iff (!i_rst_n) (r_s1_valid && !s1_adv) |=> $stable(r_mem_q))
        else $error("RAM read data changed under a stalled item");

endmodule

>>> tb/cbm_checker.sv
`timescale 1ns / 100ps

module cbm_checker
    import cbm_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_req_valid,
    input  logic      i_req_ready,
    input  logic      i_req_command,
    input  t_addr     i_req_bus_address,
    input  t_data     i_req_write_data,
    input  logic      i_rsp_valid,
    input  logic      i_rsp_ready,
    input  t_kind     i_rsp_result_kind,
    input  t_rom_addr i_rsp_rom_address,
    input  t_data     i_rsp_read_data,
    output int        o_fail_count,
    output int        o_pending
);

    typedef struct packed {
        t_kind     kind;
        t_rom_addr rom_addr;
        t_data     rdata;
    } t_bus_result;

    // Shadow copy of the mapper's bank registers and cartridge RAM.
    logic [ROM_BANK_W-1:0] rom_bank;
    logic [RAM_BANK_W-1:0] ram_bank;
    logic                  ram_enabled;
    t_data                 cart_ram [RAM_DEPTH];

    t_bus_result bus_results_due [$];
    t_bus_result predicted;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    // Applies one bus access to the shadow state and returns the result it should give.
    function automatic t_bus_result serve_access(logic cmd, t_addr addr, t_data data);
        t_bus_result res;
        t_region     region;
        res    = '0;
        region = addr[ADDR_W-1:ADDR_W-3];
        if (cmd == CMD_WRITE) begin
            res.kind = KIND_WRITE_DONE;
            case (region)
                REG_0000: begin
                    if (data == RAM_ENABLE_KEY)
                        ram_enabled = 1'b1;
                    else if (data == RAM_DISABLE_KEY)
                        ram_enabled = 1'b0;
                end
                REG_2000: begin
                    if (!addr[12])
                        rom_bank[7:0] = data;
                    else
                        rom_bank[8] = data[0];
                end
                REG_4000: begin
                    if (data <= RAM_BANK_MAX)
                        ram_bank = data[RAM_BANK_W-1:0];
                end
                REG_A000: begin
                    if (ram_enabled)
                        cart_ram[{ram_bank, addr[RAM_OFFSET_W-1:0]}] = data;
                end
                default: ;
            endcase
        end else begin
            case (region)
                REG_0000, REG_2000: begin
                    res.kind     = KIND_ROM_ADDR;
                    res.rom_addr = t_rom_addr'(addr);
                end
                REG_4000, REG_6000: begin
                    res.kind     = KIND_ROM_ADDR;
                    res.rom_addr = {rom_bank, addr[ROM_OFFSET_W-1:0]};
                end
                REG_A000: begin
                    // The enable flag gates writes only, so reads always see the store.
                    res.kind  = KIND_DATA;
                    res.rdata = cart_ram[{ram_bank, addr[RAM_OFFSET_W-1:0]}];
                end
                default: begin
                    res.kind  = KIND_DATA;
                    res.rdata = UNMAPPED_BYTE;
                end
            endcase
        end
        return res;
    endfunction

    task automatic flag_field(string field_name, int unsigned want_v, int unsigned got_v);
        $display("%0t: %s mismatch: expected %0h, actual %0h", $time, field_name,
                 want_v, got_v);
        o_fail_count++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rom_bank    = '0;
            ram_bank    = '0;
            ram_enabled = 1'b0;
            foreach (cart_ram[i])
                cart_ram[i] = '0;
            bus_results_due.delete();
        end else begin
            if (i_req_valid && i_req_ready)
                bus_results_due.push_back(serve_access(i_req_command, i_req_bus_address,
                                                       i_req_write_data));
            if (i_rsp_valid && i_rsp_ready) begin
                if (bus_results_due.size() == 0) begin
                    $display({"%0t: unexpected result: expected none, ",
                              "actual kind %0h rom %0h data %0h"},
                             $time, i_rsp_result_kind, i_rsp_rom_address, i_rsp_read_data);
                    o_fail_count++;
                end else begin
                    predicted = bus_results_due.pop_front();
                    if (i_rsp_result_kind !== predicted.kind)
                        flag_field("result_kind", predicted.kind, i_rsp_result_kind);
                    if (i_rsp_rom_address !== predicted.rom_addr)
                        flag_field("rom_address", predicted.rom_addr, i_rsp_rom_address);
                    if (i_rsp_read_data !== predicted.rdata)
                        flag_field("read_data", predicted.rdata, i_rsp_read_data);
                end
            end
        end
        o_pending = bus_results_due.size();
    end

endmodule

>>> tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import cbm_pkg::*;

    // The cycle limit also has to cover the RAM clearing pass after reset.
    localparam int CYCLE_LIMIT      = 250000;
    localparam int HOLD_OFF_CYCLES  = 300;
    localparam int ITEMS_PER_PHASE  = 210;

    logic clk;
    logic rst_n;
    int   send_idle_pct;
    int   stall_pct;
    bit   hold_request;
    int   fail_count;
    int   pending_count;
    int   cycle_count;

    cbm_req_if req_bus ();
    cbm_rsp_if rsp_bus ();

    cartridge_bank_mapper i_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_bus),
        .o_rsp   (rsp_bus)
    );

    cbm_checker u_checker (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_req_valid       (req_bus.valid),
        .i_req_ready       (req_bus.ready),
        .i_req_command     (req_bus.command),
        .i_req_bus_address (req_bus.bus_address),
        .i_req_write_data  (req_bus.write_data),
        .i_rsp_valid       (rsp_bus.valid),
        .i_rsp_ready       (rsp_bus.ready),
        .i_rsp_result_kind (rsp_bus.result_kind),
        .i_rsp_rom_address (rsp_bus.rom_address),
        .i_rsp_read_data   (rsp_bus.read_data),
        .o_fail_count      (fail_count),
        .o_pending         (pending_count)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    // Result side: random stalls, and a long hold-off on request so that the mapper backs up.
    initial begin
        rsp_bus.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_request) begin
                hold_request = 1'b0;
                rsp_bus.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge clk);
            end
            rsp_bus.ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    task automatic send_access(input logic cmd, input t_addr addr, input t_data data);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            req_bus.valid <= 1'b0;
            @(negedge clk);
        end
        req_bus.valid       <= 1'b1;
        req_bus.command     <= cmd;
        req_bus.bus_address <= addr;
        req_bus.write_data  <= data;
        @(posedge clk);
        while (!req_bus.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        req_bus.valid <= 1'b0;
        while (pending_count != 0)
            @(negedge clk);
    endtask

    // Mostly the first few bytes of a bank, so that reads find what was written.
    function automatic t_addr ram_address();
        if ($urandom_range(0, 1))
            return t_addr'(16'hA000 + $urandom_range(0, 15));
        return t_addr'(16'hA000 + $urandom_range(0, 8191));
    endfunction

    task automatic send_random_access();
        int    pick;
        logic  cmd;
        t_addr addr;
        t_data data;
        pick = $urandom_range(0, 99);
        cmd  = CMD_WRITE;
        data = t_data'($urandom);
        if (pick < 10) begin
            addr = t_addr'($urandom_range(16'h0000, 16'h1FFF));
            if ($urandom_range(0, 3) != 0)
                data = $urandom_range(0, 1) ? RAM_ENABLE_KEY : RAM_DISABLE_KEY;
        end else if (pick < 20) begin
            addr = t_addr'($urandom_range(16'h2000, 16'h2FFF));
        end else if (pick < 25) begin
            addr = t_addr'($urandom_range(16'h3000, 16'h3FFF));
        end else if (pick < 35) begin
            addr = t_addr'($urandom_range(16'h4000, 16'h5FFF));
            if ($urandom_range(0, 3) != 0)
                data = t_data'($urandom_range(0, 3));
        end else if (pick < 55) begin
            addr = ram_address();
        end else if (pick < 75) begin
            cmd  = CMD_READ;
            addr = ram_address();
        end else if (pick < 90) begin
            cmd  = CMD_READ;
            addr = t_addr'($urandom_range(16'h0000, 16'h7FFF));
        end else begin
            cmd  = $urandom_range(0, 1) ? CMD_WRITE : CMD_READ;
            addr = t_addr'($urandom);
        end
        send_access(cmd, addr, data);
    endtask

    initial begin
        rst_n               = 1'b0;
        hold_request        = 1'b0;
        send_idle_pct       = 0;
        stall_pct           = 0;
        req_bus.valid       = 1'b0;
        req_bus.command     = CMD_READ;
        req_bus.bus_address = '0;
        req_bus.write_data  = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed accesses across the address map and the register corner cases.
        send_access(CMD_READ,  16'h0000, 8'hFF);
        send_access(CMD_READ,  16'h3FFF, 8'h00);
        send_access(CMD_READ,  16'h4000, 8'hFF);
        send_access(CMD_READ,  16'hA000, 8'h00);
        send_access(CMD_WRITE, 16'hA000, 8'h5A);   // RAM still disabled, so dropped
        send_access(CMD_WRITE, 16'h0000, RAM_ENABLE_KEY);
        send_access(CMD_WRITE, 16'h1FFF, 8'h55);   // neither key: flag unchanged
        send_access(CMD_WRITE, 16'hA000, 8'hFF);
        send_access(CMD_READ,  16'hA000, 8'h00);
        send_access(CMD_WRITE, 16'h2FFF, 8'hFF);
        send_access(CMD_WRITE, 16'h3FFF, 8'h01);
        send_access(CMD_READ,  16'h7FFF, 8'h00);
        send_access(CMD_WRITE, 16'h3000, 8'hFE);
        send_access(CMD_READ,  16'h4000, 8'h00);
        send_access(CMD_WRITE, 16'h4000, RAM_BANK_MAX);
        send_access(CMD_WRITE, 16'hBFFF, 8'hA5);
        send_access(CMD_WRITE, 16'h5FFF, 8'h04);   // out of range bank number
        send_access(CMD_READ,  16'hBFFF, 8'h00);
        send_access(CMD_WRITE, 16'h0000, RAM_DISABLE_KEY);
        send_access(CMD_READ,  16'hBFFF, 8'h00);
        send_access(CMD_WRITE, 16'h6000, 8'h12);
        send_access(CMD_WRITE, 16'h8000, 8'h34);
        send_access(CMD_WRITE, 16'hFFFF, 8'h56);
        send_access(CMD_READ,  16'h8000, 8'h00);
        send_access(CMD_READ,  16'hFFFF, 8'hFF);
        wait_drained();

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 59; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 59; end
                default: begin send_idle_pct = 37; stall_pct = 37; end
            endcase
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (phase == 0 && n == 60)
                    hold_request = 1'b1;
                send_random_access();
            end
            wait_drained();
        end

        repeat (8) @(negedge clk);
        if (fail_count == 0 && pending_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
